// File: src/tkct_pkg.sv
// Package with shared types, constants and codes of the top-k count tracker.
`timescale 1ns / 1ps

package tkct_pkg;

   localparam int KEY_BITS        = 32;
   localparam int COUNT_BITS      = 32;
   localparam int RANK_BITS       = 5;
   localparam int TOP_ENTRIES_DEF = 20;

   // Operation codes carried in the opcode field of a request item.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef struct packed {
      logic                  opcode;
      logic [KEY_BITS-1:0]   word_key;
      logic [COUNT_BITS-1:0] occurrences;
   } req_type;

   typedef struct packed {
      logic                  valid_res;
      logic [RANK_BITS-1:0]  rank;
      logic [KEY_BITS-1:0]   entry_key;
      logic [COUNT_BITS-1:0] entry_count;
      logic                  last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic ins_en;
      logic emit_en;
      logic idx_clr;
      logic idx_inc;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic empty;
      logic at_last;
   } status_type;

endpackage

// File: src/top_k_count_tracker_unit.sv
// Top level of the top-k count tracker: controller and datapath.
`timescale 1ns / 1ps

// The tracker keeps up to TOP_ENTRIES (key, count) entries in a row of slot
// registers sorted by descending count, ties kept in arrival order. An insert
// item is accepted in the idle state: every slot compares its count with the
// new one in parallel, and each slot either holds, loads the new entry, or
// takes its neighbor's entry, dropping the last one when the list is full. A
// read item streams the list out one result item per cycle while the consumer
// takes each result, rank zero first, with last set on the final one; an empty
// list answers with one item whose valid_res is clear. The read stalls while a
// result waits in the output register and rsp_ready is low, and no request item
// is taken until the last result has entered the output register. Result items
// leave through a single output register, so an insert may be accepted while a
// result still waits to be taken.

module top_k_count_tracker_unit #(
   parameter int TOP_ENTRIES = tkct_pkg::TOP_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tkct_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tkct_pkg::rsp_type rsp_data
);

   tkct_pkg::cmd_type    cmd;
   tkct_pkg::status_type status;

   // The controller sequences read-outs and gates the request channel.
   tkct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the sorted slot row and the result register.
   tkct_datapath #(
      .TOP_ENTRIES (TOP_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/tkct_ctrl.sv
// Controller state machine of the top-k count tracker.
`timescale 1ns / 1ps

module tkct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_opcode,
   output logic                req_ready,
   input  tkct_pkg::status_type status,
   output tkct_pkg::cmd_type    cmd
);

   tkct_pkg::state_type state_ff;
   tkct_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tkct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tkct_pkg::ST_IDLE: begin
            if (req_valid && req_opcode == tkct_pkg::OP_READ) begin
               state_in = tkct_pkg::ST_READ;
            end
         end
         tkct_pkg::ST_READ: begin
            if (status.out_free && (status.at_last || status.empty)) begin
               state_in = tkct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tkct_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.ins_en  = 1'b0;
      cmd.emit_en = 1'b0;
      cmd.idx_clr = 1'b0;
      cmd.idx_inc = 1'b0;
      case (state_ff)
         tkct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == tkct_pkg::OP_INSERT) begin
                  cmd.ins_en = 1'b1;
               end else begin
                  cmd.idx_clr = 1'b1;
               end
            end
         end
         tkct_pkg::ST_READ: begin
            if (status.out_free) begin
               cmd.emit_en = 1'b1;
               if (status.at_last || status.empty) begin
                  cmd.idx_clr = 1'b1;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: src/tkct_datapath.sv
// Datapath of the top-k count tracker: sorted slot row, read index and output register.
`timescale 1ns / 1ps

module tkct_datapath #(
   parameter int TOP_ENTRIES = tkct_pkg::TOP_ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tkct_pkg::req_type    req_data,
   input  tkct_pkg::cmd_type    cmd,
   output tkct_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tkct_pkg::rsp_type    rsp_data
);

   localparam int IDX_W = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;
   localparam int OCC_W = $clog2(TOP_ENTRIES + 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(TOP_ENTRIES);

   logic [tkct_pkg::KEY_BITS-1:0]   key_ff [TOP_ENTRIES];
   logic [tkct_pkg::COUNT_BITS-1:0] cnt_ff [TOP_ENTRIES];
   logic [tkct_pkg::KEY_BITS-1:0]   key_in [TOP_ENTRIES];
   logic [tkct_pkg::COUNT_BITS-1:0] cnt_in [TOP_ENTRIES];
   logic [TOP_ENTRIES-1:0]          ge;

   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tkct_pkg::rsp_type rsp_ff, rsp_in;

   // A slot stays put when it is occupied and its count is at least the new one.
   // Since the row is sorted, these flags form a run of ones from slot zero.
   for (genvar i = 0; i < TOP_ENTRIES; i++) begin : g_cell
      assign ge[i] = (OCC_W'(i) < occ_ff) && (cnt_ff[i] >= req_data.occurrences);

      if (i == 0) begin : g_head
         always_comb begin
            key_in[i] = key_ff[i];
            cnt_in[i] = cnt_ff[i];
            if (cmd.ins_en && !ge[i]) begin
               key_in[i] = req_data.word_key;
               cnt_in[i] = req_data.occurrences;
            end
         end
      end else begin : g_body
         always_comb begin
            key_in[i] = key_ff[i];
            cnt_in[i] = cnt_ff[i];
            if (cmd.ins_en && !ge[i]) begin
               if (ge[i-1]) begin
                  key_in[i] = req_data.word_key;
                  cnt_in[i] = req_data.occurrences;
               end else begin
                  key_in[i] = key_ff[i-1];
                  cnt_in[i] = cnt_ff[i-1];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         key_ff[i] <= key_in[i];
         cnt_ff[i] <= cnt_in[i];
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.ins_en && occ_ff != OCC_FULL) begin
         occ_in = occ_ff + OCC_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   assign status.empty    = (occ_ff == '0);
   assign status.at_last  = ({1'b0, idx_ff} + (IDX_W+1)'(1)) == (IDX_W+1)'(occ_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit_en) begin
         rsp_in.valid_res   = !status.empty;
         rsp_in.rank        = tkct_pkg::RANK_BITS'(idx_ff);
         rsp_in.entry_key   = status.empty ? '0 : key_ff[idx_ff];
         rsp_in.entry_count = status.empty ? '0 : cnt_ff[idx_ff];
         rsp_in.last        = status.empty || status.at_last;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Occupancy never goes past the number of slots.
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("occupancy beyond slot count");

   // An insert into a list that is not full grows it by one.
   a_occ_grow: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_en && occ_ff != OCC_FULL |=> occ_ff == $past(occ_ff) + OCC_W'(1))
      else $error("insert did not grow the list");

   // An entry is only emitted into a free output register.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_en |-> status.out_free)
      else $error("result overwritten before it was taken");

   // While reading, the index stays inside the occupied part of the list.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_en && !status.empty |-> (OCC_W+1)'(idx_ff) < (OCC_W+1)'(occ_ff))
      else $error("read index past occupancy");
`endif

endmodule
